@@ rtl/tcpchk_pkg.sv @@
// Shared types, constants and checksum helper for the TCP header parse/check block.
`timescale 1ns / 1ps
package tcpchk_pkg;

  localparam int MAX_SEGMENT_BYTES = 65535;

  localparam int HdrBytes = 20;
  localparam int HdrIdxW  = $clog2(HdrBytes);

  localparam logic [16:0] CountSat  = 17'h1FFFF;
  localparam logic [16:0] MinHdrLen = 17'(HdrBytes);
  localparam logic [16:0] MaxSegLen = 17'(MAX_SEGMENT_BYTES);
  localparam logic [15:0] TcpProto  = 16'd6;
  localparam logic [16:0] SumGood   = 17'h0FFFF;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_SHORT      = 3'd1;
  localparam logic [2:0] ST_BAD_OFFSET = 3'd2;
  localparam logic [2:0] ST_TOO_LONG   = 3'd3;
  localparam logic [2:0] ST_BAD_SUM    = 3'd4;

  typedef logic [0:HdrBytes-1][7:0] hdr_bytes_t;

  // One finished segment as handed from the front to the back.
  typedef struct packed {
    hdr_bytes_t  hdr;
    logic [16:0] len;
    logic [16:0] sum;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
  } seg_rec_t;

  // Add a 16-bit word with a single end-around carry fold.
  function automatic logic [16:0] add_word(input logic [16:0] acc, input logic [15:0] w);
    logic [17:0] s;
    s = {1'b0, acc} + {2'b00, w};
    return {1'b0, s[15:0]} + {15'b0, s[17:16]};
  endfunction

endpackage

@@ rtl/tcp_segment_header_parse_check.sv @@
// Top level: TCP segment header parser with pseudo-header checksum check.
// Takes one segment byte per cycle while full is low; no bubble between bytes or segments.
// The result is on the out_ ports (empty low) once the record of the final byte has
// passed through the record queue, stage 1 and the result register.
// Throughput: one result per cycle at most; the two-entry record queue and
// the result register absorb a stall on either side.
// Reset (rst_n low, synchronous) empties the queue and pipeline, clears the sums.
`timescale 1ns / 1ps
module tcp_segment_header_parse_check
  import tcpchk_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic [31:0] in_src_ip,
  input  logic [31:0] in_dst_ip,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_status,
  output logic [15:0] out_source_port,
  output logic [15:0] out_dest_port,
  output logic [31:0] out_seq_number,
  output logic [31:0] out_ack_number,
  output logic [5:0]  out_header_bytes,
  output logic [7:0]  out_flag_bits,
  output logic [15:0] out_window_size,
  output logic [15:0] out_checksum_field,
  output logic [15:0] out_urgent_pointer,
  output logic [15:0] out_data_length
);

  logic     q_full;
  logic     q_push;
  logic     q_valid;
  logic     q_pop;
  seg_rec_t push_rec;
  seg_rec_t head_rec;

  tcpchk_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (push),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .in_src_ip    (in_src_ip),
    .in_dst_ip    (in_dst_ip),
    .q_full       (q_full),
    .in_stall     (full),
    .q_push       (q_push),
    .q_rec        (push_rec)
  );

  tcpchk_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head_rec (head_rec)
  );

  tcpchk_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_rec              (head_rec),
    .q_pop              (q_pop),
    .pop                (pop),
    .empty              (empty),
    .out_status         (out_status),
    .out_source_port    (out_source_port),
    .out_dest_port      (out_dest_port),
    .out_seq_number     (out_seq_number),
    .out_ack_number     (out_ack_number),
    .out_header_bytes   (out_header_bytes),
    .out_flag_bits      (out_flag_bits),
    .out_window_size    (out_window_size),
    .out_checksum_field (out_checksum_field),
    .out_urgent_pointer (out_urgent_pointer),
    .out_data_length    (out_data_length)
  );

endmodule

@@ rtl/tcpchk_front.sv @@
// Front end: byte intake, header capture and running word sum per segment.
`timescale 1ns / 1ps
module tcpchk_front
  import tcpchk_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic [31:0] in_src_ip,
  input  logic [31:0] in_dst_ip,
  input  logic        q_full,
  output logic        in_stall,
  output logic        q_push,
  output seg_rec_t    q_rec
);

  logic [16:0] count_r, count_nxt;
  logic [16:0] sum_r, sum_nxt;
  logic [7:0]  hold_r, hold_nxt;
  hdr_bytes_t  hdr_r, hdr_nxt;
  logic        take;
  logic        even;
  logic [15:0] word;

  assign in_stall = q_full;
  assign take     = in_valid && !q_full;
  assign even     = !count_r[0];
  assign word     = even ? {in_data_byte, 8'h00} : {hold_r, in_data_byte};

  always_comb begin
    hdr_nxt = hdr_r;
    if (count_r < MinHdrLen) begin
      hdr_nxt[count_r[HdrIdxW-1:0]] = in_data_byte;
    end
    hold_nxt  = even ? in_data_byte : hold_r;
    sum_nxt   = (!even || in_last_byte) ? add_word(sum_r, word) : sum_r;
    count_nxt = (count_r == CountSat) ? count_r : count_r + 17'd1;
  end

  assign q_push     = take && in_last_byte;
  assign q_rec.hdr    = hdr_nxt;
  assign q_rec.len    = count_nxt;
  assign q_rec.sum    = sum_nxt;
  assign q_rec.src_ip = in_src_ip;
  assign q_rec.dst_ip = in_dst_ip;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
      hold_r  <= '0;
      hdr_r   <= '0;
    end else if (take) begin
      if (in_last_byte) begin
        // start the next segment from a clean slate
        count_r <= '0;
        sum_r   <= '0;
        hold_r  <= '0;
        hdr_r   <= '0;
      end else begin
        count_r <= count_nxt;
        sum_r   <= sum_nxt;
        hold_r  <= hold_nxt;
        hdr_r   <= hdr_nxt;
      end
    end
  end

endmodule

@@ rtl/tcpchk_queue.sv @@
// Two-entry queue of finished segment records between front and back.
`timescale 1ns / 1ps
module tcpchk_queue
  import tcpchk_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  seg_rec_t push_rec,
  output logic     full,
  input  logic     pop,
  output logic     valid,
  output seg_rec_t head_rec
);

  seg_rec_t    mem_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  cnt_r;
  logic        do_push;
  logic        do_pop;

  assign full     = (cnt_r == 2'd2);
  assign valid    = (cnt_r != 2'd0);
  assign head_rec = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

`ifndef ASSERT_OFF
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("record pushed into a full queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("queue count out of range");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (!do_push && do_pop) |=> (cnt_r == $past(cnt_r) - 2'd1))
    else $error("queue count lost a pop");
`endif

endmodule

@@ rtl/tcpchk_back.sv @@
// Back end: pseudo-header sum, segment checks and result register.
`timescale 1ns / 1ps
module tcpchk_back
  import tcpchk_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  seg_rec_t    q_rec,
  output logic        q_pop,
  input  logic        pop,
  output logic        empty,
  output logic [2:0]  out_status,
  output logic [15:0] out_source_port,
  output logic [15:0] out_dest_port,
  output logic [31:0] out_seq_number,
  output logic [31:0] out_ack_number,
  output logic [5:0]  out_header_bytes,
  output logic [7:0]  out_flag_bits,
  output logic [15:0] out_window_size,
  output logic [15:0] out_checksum_field,
  output logic [15:0] out_urgent_pointer,
  output logic [15:0] out_data_length
);

  // stage 1: source address and upper destination word folded in
  logic        s1_v_r;
  hdr_bytes_t  s1_hdr_r;
  logic [16:0] s1_len_r;
  logic [15:0] s1_dip_lo_r;
  logic [16:0] s1_sum_r;
  logic [16:0] s1_sum_nxt;

  // result register
  logic        out_v_r;
  logic [2:0]  status_r;
  hdr_bytes_t  hdr_r;
  logic [5:0]  hbytes_r;
  logic [15:0] payload_r;

  logic        out_rdy;
  logic        s1_rdy;
  logic [16:0] sum_fin;
  logic [5:0]  hbytes;
  logic [2:0]  status_nxt;
  logic [15:0] payload_nxt;

  assign out_rdy = !out_v_r || pop;
  assign s1_rdy  = !s1_v_r || out_rdy;
  assign q_pop   = q_valid && s1_rdy;

  assign s1_sum_nxt = add_word(add_word(add_word(q_rec.sum, q_rec.src_ip[31:16]),
                                        q_rec.src_ip[15:0]),
                               q_rec.dst_ip[31:16]);

  assign sum_fin = add_word(add_word(add_word(s1_sum_r, s1_dip_lo_r), TcpProto),
                            s1_len_r[15:0]);
  assign hbytes  = {s1_hdr_r[12][7:4], 2'b00};

  always_comb begin
    if (s1_len_r < MinHdrLen) begin
      status_nxt = ST_SHORT;
    end else if ({11'b0, hbytes} < MinHdrLen || {11'b0, hbytes} > s1_len_r) begin
      status_nxt = ST_BAD_OFFSET;
    end else if (s1_len_r > MaxSegLen) begin
      status_nxt = ST_TOO_LONG;
    end else if (sum_fin != SumGood) begin
      status_nxt = ST_BAD_SUM;
    end else begin
      status_nxt = ST_OK;
    end
    payload_nxt = (status_nxt == ST_OK) ? (s1_len_r[15:0] - {10'b0, hbytes}) : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_rdy)  s1_v_r  <= q_valid;
      if (out_rdy) out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_hdr_r    <= q_rec.hdr;
      s1_len_r    <= q_rec.len;
      s1_dip_lo_r <= q_rec.dst_ip[15:0];
      s1_sum_r    <= s1_sum_nxt;
    end
    if (out_rdy && s1_v_r) begin
      status_r  <= status_nxt;
      hdr_r     <= s1_hdr_r;
      hbytes_r  <= hbytes;
      payload_r <= payload_nxt;
    end
  end

  assign empty              = !out_v_r;
  assign out_status         = status_r;
  assign out_source_port    = {hdr_r[0], hdr_r[1]};
  assign out_dest_port      = {hdr_r[2], hdr_r[3]};
  assign out_seq_number     = {hdr_r[4], hdr_r[5], hdr_r[6], hdr_r[7]};
  assign out_ack_number     = {hdr_r[8], hdr_r[9], hdr_r[10], hdr_r[11]};
  assign out_header_bytes   = hbytes_r;
  assign out_flag_bits      = hdr_r[13];
  assign out_window_size    = {hdr_r[14], hdr_r[15]};
  assign out_checksum_field = {hdr_r[16], hdr_r[17]};
  assign out_urgent_pointer = {hdr_r[18], hdr_r[19]};
  assign out_data_length    = payload_r;

`ifndef ASSERT_OFF
  a_pop_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> s1_v_r)
    else $error("popped record did not reach stage 1");
  a_err_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && status_r != ST_OK) |-> (payload_r == 16'd0))
    else $error("payload length nonzero on error");
  a_ok_hdr_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && status_r == ST_OK) |-> (hbytes_r >= 6'd20))
    else $error("ok status with short header length");
`endif

endmodule

@@ sim/tcpchk_tb_pkg.sv @@
// Scoreboard for the TCP header parse/check block: prediction and result matching.
`timescale 1ns / 1ps
package tcpchk_tb_pkg;
  import tcpchk_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] seq_number;
    logic [31:0] ack_number;
    logic [5:0]  header_bytes;
    logic [7:0]  flag_bits;
    logic [15:0] window_size;
    logic [15:0] checksum_field;
    logic [15:0] urgent_pointer;
    logic [15:0] data_length;
  } seg_summary_t;

  class tcp_header_scoreboard;
    seg_summary_t awaited[$];
    int           mismatches;

    bit [16:0] seen_bytes;
    bit [16:0] ones_sum;
    bit [7:0]  word_hi;
    bit [7:0]  hdr_cap[HdrBytes];

    function new();
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      seen_bytes = '0;
      ones_sum   = '0;
      word_hi    = '0;
      foreach (hdr_cap[i]) hdr_cap[i] = '0;
    endfunction

    // One's-complement add with a single end-around carry.
    function void add_to_sum(bit [15:0] w);
      bit [17:0] s;
      s = {1'b0, ones_sum} + {2'b00, w};
      ones_sum = {1'b0, s[15:0]} + {15'b0, s[17:16]};
    endfunction

    function void report(string what);
      mismatches++;
      $display("mismatch %0d at %0t: %s", mismatches, $time, what);
    endfunction

    // Note one accepted segment byte; on the final one, queue the expected header summary.
    function void take_byte(bit [7:0] b, bit last, bit [31:0] sip, bit [31:0] dip);
      seg_summary_t r;
      bit [16:0]    p;
      bit [16:0]    len;
      bit [16:0]    hlen;
      p = seen_bytes;
      if (p < HdrBytes) hdr_cap[p[4:0]] = b;
      if (!p[0]) begin
        word_hi = b;
        if (last) add_to_sum({b, 8'h00});
      end else begin
        add_to_sum({word_hi, b});
      end
      if (seen_bytes != CountSat) seen_bytes++;
      if (!last) return;

      len  = seen_bytes;
      hlen = {11'b0, hdr_cap[12][7:4], 2'b00};
      add_to_sum(sip[31:16]);
      add_to_sum(sip[15:0]);
      add_to_sum(dip[31:16]);
      add_to_sum(dip[15:0]);
      add_to_sum(TcpProto);
      add_to_sum(len[15:0]);

      if (len < MinHdrLen) r.status = ST_SHORT;
      else if (hlen < MinHdrLen || hlen > len) r.status = ST_BAD_OFFSET;
      else if (int'(len) > MAX_SEGMENT_BYTES || len > 17'h0FFFF) r.status = ST_TOO_LONG;
      else if (ones_sum != SumGood) r.status = ST_BAD_SUM;
      else r.status = ST_OK;

      r.source_port    = {hdr_cap[0], hdr_cap[1]};
      r.dest_port      = {hdr_cap[2], hdr_cap[3]};
      r.seq_number     = {hdr_cap[4], hdr_cap[5], hdr_cap[6], hdr_cap[7]};
      r.ack_number     = {hdr_cap[8], hdr_cap[9], hdr_cap[10], hdr_cap[11]};
      r.header_bytes   = hlen[5:0];
      r.flag_bits      = hdr_cap[13];
      r.window_size    = {hdr_cap[14], hdr_cap[15]};
      r.checksum_field = {hdr_cap[16], hdr_cap[17]};
      r.urgent_pointer = {hdr_cap[18], hdr_cap[19]};
      r.data_length    = (r.status == ST_OK) ? 16'(len - hlen) : 16'h0000;
      awaited.push_back(r);
      clear();
    endfunction

    function void cmp(string name, logic [31:0] got, bit [31:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
    endfunction

    function void match_header(seg_summary_t got);
      seg_summary_t want;
      if (awaited.size() == 0) begin
        report("result word with nothing awaited");
        return;
      end
      want = awaited.pop_front();
      cmp("status", got.status, want.status);
      cmp("source_port", got.source_port, want.source_port);
      cmp("dest_port", got.dest_port, want.dest_port);
      cmp("seq_number", got.seq_number, want.seq_number);
      cmp("ack_number", got.ack_number, want.ack_number);
      cmp("header_bytes", got.header_bytes, want.header_bytes);
      cmp("flag_bits", got.flag_bits, want.flag_bits);
      cmp("window_size", got.window_size, want.window_size);
      cmp("checksum_field", got.checksum_field, want.checksum_field);
      cmp("urgent_pointer", got.urgent_pointer, want.urgent_pointer);
      cmp("data_length", got.data_length, want.data_length);
    endfunction
  endclass

endpackage

@@ sim/tcp_segment_header_parse_check_test.sv @@
// Testbench top for the TCP segment header parse/check block.
`timescale 1ns / 1ps
module tcp_segment_header_parse_check_test;
  import tcpchk_pkg::*;
  import tcpchk_tb_pkg::*;

  localparam int RandomBytes = 1350;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic [7:0]  in_data_byte = '0;
  logic        in_last_byte = 1'b0;
  logic [31:0] in_src_ip = '0;
  logic [31:0] in_dst_ip = '0;
  logic        full;
  logic        empty;
  logic [2:0]  out_status;
  logic [15:0] out_source_port;
  logic [15:0] out_dest_port;
  logic [31:0] out_seq_number;
  logic [31:0] out_ack_number;
  logic [5:0]  out_header_bytes;
  logic [7:0]  out_flag_bits;
  logic [15:0] out_window_size;
  logic [15:0] out_checksum_field;
  logic [15:0] out_urgent_pointer;
  logic [15:0] out_data_length;

  tcp_header_scoreboard sb = new();
  int sender_max_gap   = 6;
  int receiver_max_gap = 6;
  bit hold_off_request = 1'b0;

  always #4 clk = ~clk;

  tcp_segment_header_parse_check dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .in_src_ip          (in_src_ip),
    .in_dst_ip          (in_dst_ip),
    .empty              (empty),
    .pop                (pop),
    .out_status         (out_status),
    .out_source_port    (out_source_port),
    .out_dest_port      (out_dest_port),
    .out_seq_number     (out_seq_number),
    .out_ack_number     (out_ack_number),
    .out_header_bytes   (out_header_bytes),
    .out_flag_bits      (out_flag_bits),
    .out_window_size    (out_window_size),
    .out_checksum_field (out_checksum_field),
    .out_urgent_pointer (out_urgent_pointer),
    .out_data_length    (out_data_length)
  );

  initial begin
    #8_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic offer_byte(input logic [7:0] b, input logic last, input logic [31:0] sip,
                            input logic [31:0] dip);
    push         <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    in_src_ip    <= sip;
    in_dst_ip    <= dip;
    do @(posedge clk); while (full);
    sb.take_byte(b, last, sip, dip);
  endtask

  task automatic send_segment(ref logic [7:0] seg[$], input logic [31:0] sip,
                              input logic [31:0] dip);
    int   gap;
    logic last;
    foreach (seg[i]) begin
      last = (i == seg.size() - 1);
      gap  = $urandom_range(0, sender_max_gap);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // addresses on non-final bytes are don't-care: randomize them
      offer_byte(seg[i], last, last ? sip : $urandom(), last ? dip : $urandom());
    end
  endtask

  function automatic void build_segment(ref logic [7:0] seg[$], input int len, input int words);
    seg.delete();
    repeat (len) seg.push_back(8'($urandom()));
    if (len > 12) seg[12] = {4'(words), seg[12][3:0]};
  endfunction

  // Write a checksum field that makes the segment plus pseudo-header sum to all ones.
  function automatic void seal(ref logic [7:0] seg[$], input logic [31:0] sip,
                               input logic [31:0] dip);
    logic [31:0] acc;
    int          i;
    seg[16] = 8'h00;
    seg[17] = 8'h00;
    acc = 32'(sip[31:16]) + sip[15:0] + dip[31:16] + dip[15:0] + 6 + seg.size();
    for (i = 0; i < seg.size(); i += 2)
      acc += {seg[i], (i + 1 < seg.size()) ? seg[i + 1] : 8'h00};
    while (acc[31:16] != 0) acc = acc[15:0] + acc[31:16];
    seg[16] = ~acc[15:8];
    seg[17] = ~acc[7:0];
  endfunction

  initial begin : drain
    int           gap;
    seg_summary_t got;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        pop <= 1'b0;
        repeat (400) @(posedge clk);
      end
      gap = $urandom_range(0, receiver_max_gap);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      got = {out_status, out_source_port, out_dest_port, out_seq_number, out_ack_number,
             out_header_bytes, out_flag_bits, out_window_size, out_checksum_field,
             out_urgent_pointer, out_data_length};
      sb.match_header(got);
    end
  end

  initial begin : stimulus
    logic [7:0]  seg[$];
    logic [31:0] sip;
    logic [31:0] dip;
    int          off;
    int          len;
    int          mode;
    int          sent;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single byte, and one short of a full header
    build_segment(seg, 1, 0);
    send_segment(seg, 32'h0, 32'h0);
    build_segment(seg, 19, 5);
    send_segment(seg, 32'hFFFF_FFFF, 32'h0);
    // minimum header, all ones, then all zeros
    build_segment(seg, 20, 5);
    foreach (seg[i]) seg[i] = 8'hFF;
    seg[12] = 8'h5F;
    seal(seg, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_segment(seg, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    build_segment(seg, 20, 5);
    foreach (seg[i]) seg[i] = 8'h00;
    seg[12] = 8'h50;
    seal(seg, 32'h0, 32'h0);
    send_segment(seg, 32'h0, 32'h0);
    // largest header, header under minimum, header past end, zero offset
    sip = $urandom();
    dip = $urandom();
    build_segment(seg, 60, 15);
    seal(seg, sip, dip);
    send_segment(seg, sip, dip);
    build_segment(seg, 40, 4);
    seal(seg, sip, dip);
    send_segment(seg, sip, dip);
    build_segment(seg, 30, 10);
    seal(seg, sip, dip);
    send_segment(seg, sip, dip);
    build_segment(seg, 25, 0);
    seal(seg, sip, dip);
    send_segment(seg, sip, dip);
    // odd length with padding, then a flipped byte so the checksum check fails
    build_segment(seg, 41, 5);
    seal(seg, sip, dip);
    send_segment(seg, sip, dip);
    build_segment(seg, 48, 8);
    seal(seg, sip, dip);
    seg[30] ^= 8'h01;
    send_segment(seg, sip, dip);

    // stall the receiver at full rate so the block backs up
    sender_max_gap = 0;
    hold_off_request = 1'b1;
    sent = 0;
    while (sent < RandomBytes) begin
      sip  = $urandom();
      dip  = $urandom();
      mode = $urandom_range(0, 99);
      off  = $urandom_range(5, 15);
      if (mode < 75) begin
        len = off * 4 + $urandom_range(0, 24);
        build_segment(seg, len, off);
        seal(seg, sip, dip);
        if ($urandom_range(0, 9) == 0)
          seg[$urandom_range(0, len - 1)] ^= 8'(1 << $urandom_range(0, 7));
      end else if (mode < 90) begin
        len = $urandom_range(1, 70);
        build_segment(seg, len, $urandom_range(0, 15));
      end else begin
        // truncated: ends inside its own header
        len = $urandom_range(1, off * 4 - 1);
        build_segment(seg, len, off);
      end
      send_segment(seg, sip, dip);
      sent += len;
      if (sent > 500) sender_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 6;
      receiver_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 6;
    end
    push <= 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/tcpchk_pkg.sv
rtl/tcpchk_front.sv
rtl/tcpchk_queue.sv
rtl/tcpchk_back.sv
rtl/tcp_segment_header_parse_check.sv
sim/tcpchk_tb_pkg.sv
sim/tcp_segment_header_parse_check_test.sv
